// ----- hdl/e2q_pkg.sv -----
// e2q_pkg: shared types and constants for the euler to quaternion pipeline
// no dependencies

package e2q_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam int QW = 34;

    typedef logic signed [QW-1:0] q30_t;

    localparam logic signed [QW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
    localparam logic signed [QW-1:0] ROUND_HALF = 34'sh020000000;

    function automatic logic signed [QW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [QW-1:0] v;
        case (idx)
            5'd0:  v = 34'sh020000000;
            5'd1:  v = 34'sh012E4051E;
            5'd2:  v = 34'sh009FB385B;
            5'd3:  v = 34'sh0051111D4;
            5'd4:  v = 34'sh0028B0D43;
            5'd5:  v = 34'sh00145D7E1;
            5'd6:  v = 34'sh000A2F61E;
            5'd7:  v = 34'sh000517C55;
            5'd8:  v = 34'sh00028BE53;
            5'd9:  v = 34'sh000145F2F;
            5'd10: v = 34'sh0000A2F98;
            5'd11: v = 34'sh0000517CC;
            5'd12: v = 34'sh000028BE6;
            5'd13: v = 34'sh0000145F3;
            5'd14: v = 34'sh000000A2F9;
            5'd15: v = 34'sh00000517C;
            5'd16: v = 34'sh0000028BE;
            5'd17: v = 34'sh00000145F;
            5'd18: v = 34'sh000000A2F;
            5'd19: v = 34'sh000000517;
            5'd20: v = 34'sh00000028B;
            5'd21: v = 34'sh000000145;
            5'd22: v = 34'sh0000000A2;
            5'd23: v = 34'sh000000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    // product of two q30 values brought back to q30 with rounding
    function automatic logic signed [QW-1:0] mul_q30(input logic signed [QW-1:0] a,
                                                     input logic signed [QW-1:0] b);
        logic signed [2*QW-1:0] p;
        p = (2*QW)'(a) * (2*QW)'(b) + (2*QW)'(ROUND_HALF);
        return p[QW+29:30];
    endfunction

endpackage

// ----- hdl/e2q_cordic.sv -----
// e2q_cordic: pipelined rotation-mode cordic giving half-angle sine and cosine in q30
// depends on e2q_pkg

module e2q_cordic #(
    parameter int STEPS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [16:0]   angle,
    output logic                 out_valid,
    output e2q_pkg::q30_t        sin_val,
    output e2q_pkg::q30_t        cos_val
);
    import e2q_pkg::*;

    logic           v_reg   [STEPS+1];
    q30_t           x_reg   [STEPS+1];
    q30_t           y_reg   [STEPS+1];
    q30_t           z_reg   [STEPS+1];
    logic           neg_reg [STEPS+1];

    logic signed [17:0] a_fold;
    logic               neg_in;
    q30_t               z_in;

    always_comb
    begin
        neg_in = 1'b0;
        a_fold = {angle[16], angle};
        if (angle > 17'sd32768)
        begin
            a_fold = {angle[16], angle} - 18'sd65536;
            neg_in = 1'b1;
        end
        else if (angle < -17'sd32768)
        begin
            a_fold = {angle[16], angle} + 18'sd65536;
            neg_in = 1'b1;
        end
        z_in = {{(QW-32){a_fold[17]}}, a_fold[16:0], 15'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]   <= CORDIC_GAIN;
        y_reg[0]   <= '0;
        z_reg[0]   <= z_in;
        neg_reg[0] <= neg_in;
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        q30_t dx, dy, at;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = (i < ATAN_ENTRIES) ? atan_entry(5'(i)) : '0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            neg_reg[i+1] <= neg_reg[i];
            if (i >= ATAN_ENTRIES)
            begin
                x_reg[i+1] <= x_reg[i];
                y_reg[i+1] <= y_reg[i];
                z_reg[i+1] <= z_reg[i];
            end
            else if (!z_reg[i][QW-1])
            begin
                x_reg[i+1] <= x_reg[i] - dx;
                y_reg[i+1] <= y_reg[i] + dy;
                z_reg[i+1] <= z_reg[i] - at;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + dx;
                y_reg[i+1] <= y_reg[i] - dy;
                z_reg[i+1] <= z_reg[i] + at;
            end
        end
    end

    assign out_valid = v_reg[STEPS];
    assign sin_val   = neg_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
    assign cos_val   = neg_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];

endmodule

// ----- hdl/e2q_combine.sv -----
// e2q_combine: pipelined triple products, scaling by 32767 and saturation
// depends on e2q_pkg

module e2q_combine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  e2q_pkg::q30_t        sp,
    input  e2q_pkg::q30_t        cp,
    input  e2q_pkg::q30_t        sy,
    input  e2q_pkg::q30_t        cy,
    input  e2q_pkg::q30_t        sr,
    input  e2q_pkg::q30_t        cr,
    output logic                 out_valid,
    output logic signed [15:0]   quat_x,
    output logic signed [15:0]   quat_y,
    output logic signed [15:0]   quat_z,
    output logic signed [15:0]   quat_w
);
    import e2q_pkg::*;

    localparam int SW = QW + 16;

    logic [4:0] v_reg;
    q30_t crsp_reg, crcp_reg, srcp_reg, srsp_reg, sy_reg, cy_reg;
    q30_t p_reg [8];
    q30_t s_reg [4];
    logic signed [SW-1:0] m_reg [4];
    logic signed [15:0] q_reg [4];
    q30_t s_next [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    assign s_next[0] = p_reg[0] - p_reg[1];
    assign s_next[1] = -p_reg[2] - p_reg[3];
    assign s_next[2] = p_reg[4] - p_reg[5];
    assign s_next[3] = p_reg[6] + p_reg[7];

    always_ff @(posedge clk)
    begin
        crsp_reg <= mul_q30(cr, sp);
        crcp_reg <= mul_q30(cr, cp);
        srcp_reg <= mul_q30(sr, cp);
        srsp_reg <= mul_q30(sr, sp);
        sy_reg   <= sy;
        cy_reg   <= cy;
        p_reg[0] <= mul_q30(crsp_reg, sy_reg);
        p_reg[1] <= mul_q30(srcp_reg, cy_reg);
        p_reg[2] <= mul_q30(crsp_reg, cy_reg);
        p_reg[3] <= mul_q30(srcp_reg, sy_reg);
        p_reg[4] <= mul_q30(crcp_reg, sy_reg);
        p_reg[5] <= mul_q30(srsp_reg, cy_reg);
        p_reg[6] <= mul_q30(crcp_reg, cy_reg);
        p_reg[7] <= mul_q30(srsp_reg, sy_reg);
        for (int k = 0; k < 4; k++)
        begin
            s_reg[k] <= s_next[k];
            m_reg[k] <= SW'(s_reg[k]) * SW'(32767) + SW'(ROUND_HALF);
        end
        for (int k = 0; k < 4; k++)
        begin
            if ((m_reg[k] >>> 30) > SW'(32767))
            begin
                q_reg[k] <= 16'sh7FFF;
            end
            else if ((m_reg[k] >>> 30) < -SW'(32768))
            begin
                q_reg[k] <= -16'sh8000;
            end
            else
            begin
                q_reg[k] <= m_reg[k][45:30];
            end
        end
    end

    assign out_valid = v_reg[4];
    assign quat_x = q_reg[0];
    assign quat_y = q_reg[1];
    assign quat_z = q_reg[2];
    assign quat_w = q_reg[3];

endmodule

// ----- hdl/euler_to_quaternion.sv -----
// euler_to_quaternion: top level, angle fold, three cordic pipelines and combiner
// depends on e2q_pkg, e2q_cordic, e2q_combine

// A new angle beat may start every cycle; busy is always low. Each result appears
// for one cycle, with done high, once its beat has passed the input register, one
// register per cordic iteration and the product pipeline.
// The receiver cannot stall the block, so results must be taken when done is high.
module euler_to_quaternion #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [15:0]   pitch_angle,
    input  logic signed [15:0]   yaw_angle,
    input  logic signed [15:0]   roll_angle,
    output logic                 done,
    output logic signed [15:0]   quat_x,
    output logic signed [15:0]   quat_y,
    output logic signed [15:0]   quat_z,
    output logic signed [15:0]   quat_w
);
    import e2q_pkg::*;

    logic signed [16:0] p_adj, y_adj, r_adj;
    logic               go;
    logic               vp, vy, vr;
    q30_t               sp, cp, sy, cy, sr, cr;

    assign busy = 1'b0;
    assign go   = start && !busy;

    assign p_adj = {pitch_angle[15], pitch_angle};
    assign r_adj = (roll_angle > 16'sd16384) ? {roll_angle[15], roll_angle} - 17'sh10000
                                             : {roll_angle[15], roll_angle};
    assign y_adj = (yaw_angle < -16'sd16384) ? {yaw_angle[15], yaw_angle} + 17'sh10000
                                             : {yaw_angle[15], yaw_angle};

    e2q_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .clk(clk), .rst_n(rst_n), .in_valid(go), .angle(p_adj),
        .out_valid(vp), .sin_val(sp), .cos_val(cp)
    );

    e2q_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .clk(clk), .rst_n(rst_n), .in_valid(go), .angle(y_adj),
        .out_valid(vy), .sin_val(sy), .cos_val(cy)
    );

    e2q_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .clk(clk), .rst_n(rst_n), .in_valid(go), .angle(r_adj),
        .out_valid(vr), .sin_val(sr), .cos_val(cr)
    );

    e2q_combine u_combine (
        .clk(clk), .rst_n(rst_n), .in_valid(vp),
        .sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr),
        .out_valid(done),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
    );

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (vp == vy) && (vy == vr))
        else $error("cordic lanes out of step");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> ##(CORDIC_STEPS + 6) done)
        else $error("result missing after start");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(vp, 5))
        else $error("result without matching beat");

endmodule
